// ----- design/four_channel_root_counter_timer_unit_assert.svh -----
// Assertion macros used by the port checker of the counter/timer unit.
`ifndef FOUR_CHANNEL_ROOT_COUNTER_TIMER_UNIT_ASSERT_SVH
`define FOUR_CHANNEL_ROOT_COUNTER_TIMER_UNIT_ASSERT_SVH

// Checks that c holds in the same cycle whenever a holds.
`define RCNT_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("rcnt: port assertion failed");

// Checks that c holds in the cycle after a holds.
`define RCNT_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("rcnt: port assertion failed");

`endif

// ----- design/rcnt_pkg.sv -----
// Shared constants, codes and types of the four-channel counter/timer unit.
`timescale 1ns / 1ps

package rcnt_pkg;

  localparam int CHANNELS  = 4;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int STEP_BIAS = 2;

  localparam int CNT_W  = 16;
  localparam int MODE_W = 10;
  localparam int RATE_W = 20;
  localparam int OP_W   = 3;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 8;
  localparam int M_TDATA_W = 24;
  localparam int IRQ_LSB   = CNT_W;
  localparam int IRQ_MSB   = CNT_W + CHANNELS - 1;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_COUNT  = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_MODE   = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_TARGET = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_COUNT  = 3'd4;

  localparam logic [CH_W-1:0] CH_DOT   = 2'd0;
  localparam logic [CH_W-1:0] CH_HBL   = 2'd1;
  localparam logic [CH_W-1:0] CH_SYS   = 2'd2;
  localparam logic [CH_W-1:0] CH_VSYNC = 2'd3;

  // Mode register bits.
  localparam int MODE_STOP = 0;
  localparam int MODE_TGT  = 4;
  localparam int MODE_REP  = 6;
  localparam logic [MODE_W-1:0] MODE_IRQ_MASK = 10'h030;
  localparam logic [MODE_W-1:0] MODE_VSYNC    = 10'h058;
  localparam logic [1:0] CLK_SEL_DIV  = 2'b01;
  localparam logic [1:0] CLK_SEL_SYS8 = 2'b10;
  localparam int RATE_SYS8 = 8;

  localparam longint RATE3_RST = 564480;
  localparam longint DIV_LINE  = 262;
  localparam longint DIV_PIX   = 386 * 262;

  // Exact reciprocal constants for quotients of RATE_W-bit values.
  localparam int     LINE_SH = RATE_W + $clog2(DIV_LINE);
  localparam int     PIX_SH  = RATE_W + $clog2(DIV_PIX);
  localparam longint LINE_M  = ((64'd1 << LINE_SH) + DIV_LINE - 1) / DIV_LINE;
  localparam longint PIX_M   = ((64'd1 << PIX_SH) + DIV_PIX - 1) / DIV_PIX;
  localparam int     RECIP_W = RATE_W + 2;
  localparam int     RPROD_W = RATE_W + RECIP_W;
  localparam int LINE_Q_W = $clog2(((64'd1 << RATE_W) - 1) / DIV_LINE + 1);
  localparam int PIX_Q_W  = $clog2(((64'd1 << RATE_W) - 1) / DIV_PIX + 1);

  localparam int     PROD_W  = CNT_W + RATE_W;
  localparam int     TICKS_W =
    $clog2((((64'd1 << CNT_W) - 1) * ((64'd1 << RATE_W) - 1)) / STEP_BIAS + 1);
  localparam longint TICKS_RST_IDLE  = ((64'd1 << CNT_W) - 1) / STEP_BIAS;
  localparam longint TICKS_RST_VSYNC = RATE3_RST / STEP_BIAS;

  typedef struct packed {
    logic                tick;
    logic                wr_count;
    logic                wr_mode;
    logic                wr_target;
    logic                cfg_wr;
    logic [CNT_W-1:0]    value;
    logic [RATE_W-1:0]   cfg_rate;
    logic [LINE_Q_W-1:0] div_line;
    logic [PIX_Q_W-1:0]  div_pix;
  } chan_ctrl_t;

endpackage

// ----- design/rcnt_rate_div.sv -----
// Derived pixel and line clock rates, taken from the vsync rate as it is written.
`timescale 1ns / 1ps

module rcnt_rate_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rcnt_pkg::RATE_W-1:0]  cfg_wr_data,
  output logic [rcnt_pkg::LINE_Q_W-1:0] div_line,
  output logic [rcnt_pkg::PIX_Q_W-1:0]  div_pix
);

  logic [rcnt_pkg::RPROD_W-1:0]  line_prod;
  logic [rcnt_pkg::RPROD_W-1:0]  pix_prod;
  logic [rcnt_pkg::LINE_Q_W-1:0] line_q;
  logic [rcnt_pkg::PIX_Q_W-1:0]  pix_q;

  assign line_prod = rcnt_pkg::RPROD_W'(cfg_wr_data) *
                     rcnt_pkg::RPROD_W'(rcnt_pkg::LINE_M);
  assign pix_prod  = rcnt_pkg::RPROD_W'(cfg_wr_data) *
                     rcnt_pkg::RPROD_W'(rcnt_pkg::PIX_M);
  assign line_q = rcnt_pkg::LINE_Q_W'(line_prod >> rcnt_pkg::LINE_SH);
  assign pix_q  = rcnt_pkg::PIX_Q_W'(pix_prod >> rcnt_pkg::PIX_SH);

  // A quotient of zero is held at one.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_line <= rcnt_pkg::LINE_Q_W'(rcnt_pkg::RATE3_RST / rcnt_pkg::DIV_LINE);
      div_pix  <= rcnt_pkg::PIX_Q_W'(rcnt_pkg::RATE3_RST / rcnt_pkg::DIV_PIX);
    end else if (cfg_wr_en) begin
      div_line <= (line_q == '0) ? rcnt_pkg::LINE_Q_W'(1) : line_q;
      div_pix  <= (pix_q == '0) ? rcnt_pkg::PIX_Q_W'(1) : pix_q;
    end
  end

endmodule

// ----- design/rcnt_channel.sv -----
// One timer channel: prescaler, elapsed units, limit countdown and restart logic.
`timescale 1ns / 1ps

module rcnt_channel (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rcnt_pkg::CH_W-1:0]  id,
  input  rcnt_pkg::chan_ctrl_t       ctrl,
  output logic [rcnt_pkg::CNT_W-1:0] count_val,
  output logic                       fire
);

  logic [rcnt_pkg::CNT_W-1:0]   base;
  logic [rcnt_pkg::CNT_W-1:0]   base_next;
  logic [rcnt_pkg::RATE_W-1:0]  prescale;
  logic [rcnt_pkg::RATE_W-1:0]  prescale_next;
  logic [rcnt_pkg::CNT_W-1:0]   elapsed;
  logic [rcnt_pkg::CNT_W-1:0]   elapsed_next;
  logic [rcnt_pkg::TICKS_W-1:0] ticks_left;
  logic [rcnt_pkg::TICKS_W-1:0] ticks_left_next;
  logic                         armed;
  logic                         armed_next;
  logic [rcnt_pkg::MODE_W-1:0]  mode;
  logic [rcnt_pkg::MODE_W-1:0]  mode_next;
  logic [rcnt_pkg::CNT_W-1:0]   target;
  logic [rcnt_pkg::CNT_W-1:0]   target_next;
  logic [rcnt_pkg::RATE_W-1:0]  rate;
  logic [rcnt_pkg::RATE_W-1:0]  rate_next;

  logic [rcnt_pkg::RATE_W:0]    prescale_inc;
  logic [rcnt_pkg::RATE_W-1:0]  mode_rate;
  logic [1:0]                   clk_sel;
  logic                         restart;
  logic                         keep_arm;
  logic                         arm_rule;
  logic [rcnt_pkg::CNT_W-1:0]   limit;
  logic [rcnt_pkg::CNT_W-1:0]   span;
  logic [rcnt_pkg::PROD_W-1:0]  prod;
  logic [rcnt_pkg::TICKS_W-1:0] restart_ticks;

  assign clk_sel = ctrl.value[9:8];

  always_comb begin
    unique case (id)
      rcnt_pkg::CH_DOT: begin
        mode_rate = (clk_sel == rcnt_pkg::CLK_SEL_DIV) ?
                    rcnt_pkg::RATE_W'(ctrl.div_pix) : rcnt_pkg::RATE_W'(1);
      end
      rcnt_pkg::CH_HBL: begin
        mode_rate = (clk_sel == rcnt_pkg::CLK_SEL_DIV) ?
                    rcnt_pkg::RATE_W'(ctrl.div_line) : rcnt_pkg::RATE_W'(1);
      end
      rcnt_pkg::CH_SYS: begin
        mode_rate = (clk_sel == rcnt_pkg::CLK_SEL_SYS8) ?
                    rcnt_pkg::RATE_W'(rcnt_pkg::RATE_SYS8) : rcnt_pkg::RATE_W'(1);
      end
      default: begin
        mode_rate = rate;
      end
    endcase
  end

  assign prescale_inc = {1'b0, prescale} + (rcnt_pkg::RATE_W + 1)'(1);
  assign fire = ctrl.tick && armed && (ticks_left <= rcnt_pkg::TICKS_W'(1));

  always_comb begin
    base_next     = base;
    mode_next     = mode;
    target_next   = target;
    rate_next     = rate;
    prescale_next = prescale;
    elapsed_next  = elapsed;
    restart       = 1'b0;
    keep_arm      = 1'b1;

    if (ctrl.tick) begin
      if (prescale_inc >= {1'b0, rate}) begin
        prescale_next = '0;
        elapsed_next  = elapsed + rcnt_pkg::CNT_W'(1);
      end else begin
        prescale_next = prescale_inc[rcnt_pkg::RATE_W-1:0];
      end
      if (fire) begin
        base_next = '0;
        restart   = 1'b1;
        keep_arm  = mode[rcnt_pkg::MODE_REP];
      end
    end

    priority if (ctrl.wr_count) begin
      base_next = ctrl.value;
      restart   = 1'b1;
    end else if (ctrl.wr_mode) begin
      mode_next = ctrl.value[rcnt_pkg::MODE_W-1:0];
      base_next = '0;
      rate_next = mode_rate;
      restart   = 1'b1;
    end else if (ctrl.wr_target) begin
      target_next = ctrl.value;
      restart     = 1'b1;
    end else begin
    end

    if (ctrl.cfg_wr && (id == rcnt_pkg::CH_VSYNC)) begin
      rate_next = ctrl.cfg_rate;
    end

    if (restart) begin
      prescale_next = '0;
      elapsed_next  = '0;
    end
  end

  assign limit = mode_next[rcnt_pkg::MODE_TGT] ? target_next : '1;
  assign span  = limit - base_next;
  assign prod  = rcnt_pkg::PROD_W'(span) * rcnt_pkg::PROD_W'(rate_next);
  assign restart_ticks = rcnt_pkg::TICKS_W'(prod / rcnt_pkg::STEP_BIAS);
  assign arm_rule = (!mode_next[rcnt_pkg::MODE_STOP] || (id != rcnt_pkg::CH_SYS)) &&
                    ((mode_next & rcnt_pkg::MODE_IRQ_MASK) != '0);

  always_comb begin
    if (restart) begin
      ticks_left_next = restart_ticks;
      armed_next      = arm_rule && keep_arm;
    end else begin
      ticks_left_next = (ctrl.tick && armed) ?
                        ticks_left - rcnt_pkg::TICKS_W'(1) : ticks_left;
      armed_next      = armed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      prescale <= '0;
      elapsed  <= '0;
      if (id == rcnt_pkg::CH_VSYNC) begin
        mode       <= rcnt_pkg::MODE_VSYNC;
        target     <= rcnt_pkg::CNT_W'(1);
        rate       <= rcnt_pkg::RATE_W'(rcnt_pkg::RATE3_RST);
        ticks_left <= rcnt_pkg::TICKS_W'(rcnt_pkg::TICKS_RST_VSYNC);
        armed      <= 1'b1;
      end else begin
        mode       <= '0;
        target     <= '0;
        rate       <= rcnt_pkg::RATE_W'(1);
        ticks_left <= rcnt_pkg::TICKS_W'(rcnt_pkg::TICKS_RST_IDLE);
        armed      <= 1'b0;
      end
    end else begin
      base       <= base_next;
      prescale   <= prescale_next;
      elapsed    <= elapsed_next;
      mode       <= mode_next;
      target     <= target_next;
      rate       <= rate_next;
      ticks_left <= ticks_left_next;
      armed      <= armed_next;
    end
  end

  assign count_val = rcnt_pkg::CNT_W'(base + rcnt_pkg::CNT_W'(rcnt_pkg::STEP_BIAS) * elapsed);

endmodule

// ----- design/four_channel_root_counter_timer_unit.sv -----
// Top level of the four-channel counter/timer unit: beat registers, rate divider and channel array.
//
//   Group     Dir  Contents (lowest bit first)
//   s_*       in   tdata: value[15:0]; tuser: opcode[2:0], channel[4:3], zero pad
//   m_*       out  tdata: read_data[15:0], irq_bits[19:16], zero pad
//   cfg_wr_*  in   vsync_rate[19:0], written when cfg_wr_en is high
//
// One beat is accepted every cycle unless a low m_tready stalls the result register.
// The four channels update in parallel in one pass between the input register and
// the result register, bounded by the restart multiply of each channel.
// While the result register is held by a low m_tready, at most one further beat
// waits in the input register. Reset is synchronous.
`timescale 1ns / 1ps

module four_channel_root_counter_timer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rcnt_pkg::RATE_W-1:0]   cfg_wr_data,   // vsync_rate
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rcnt_pkg::S_TDATA_W-1:0] s_tdata,      // value[15:0]
  input  logic [rcnt_pkg::S_TUSER_W-1:0] s_tuser,      // opcode[2:0], channel[4:3]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rcnt_pkg::M_TDATA_W-1:0] m_tdata       // read_data[15:0], irq_bits[19:16]
);

  logic                          in_valid;
  logic [rcnt_pkg::OP_W-1:0]     in_op;
  logic [rcnt_pkg::CH_W-1:0]     in_ch;
  logic [rcnt_pkg::CNT_W-1:0]    in_val;
  logic                          advance;

  logic                          out_valid;
  logic [rcnt_pkg::CNT_W-1:0]    out_rd;
  logic [rcnt_pkg::CHANNELS-1:0] out_irq;

  logic [rcnt_pkg::LINE_Q_W-1:0] div_line;
  logic [rcnt_pkg::PIX_Q_W-1:0]  div_pix;
  logic [rcnt_pkg::RATE_W-1:0]   cfg_rate;
  rcnt_pkg::chan_ctrl_t          ctrl [rcnt_pkg::CHANNELS];
  logic [rcnt_pkg::CNT_W-1:0]    count_val [rcnt_pkg::CHANNELS];
  logic [rcnt_pkg::CHANNELS-1:0] fire;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op  <= s_tuser[rcnt_pkg::OP_W-1:0];
      in_ch  <= s_tuser[rcnt_pkg::OP_W +: rcnt_pkg::CH_W];
      in_val <= s_tdata[rcnt_pkg::CNT_W-1:0];
    end
  end

  rcnt_rate_div u_rate_div (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .div_line    (div_line),
    .div_pix     (div_pix)
  );

  assign cfg_rate = (cfg_wr_data == '0) ? rcnt_pkg::RATE_W'(1) : cfg_wr_data;

  for (genvar i = 0; i < rcnt_pkg::CHANNELS; i++) begin : g_chan
    logic sel;

    assign sel = advance && (in_ch == rcnt_pkg::CH_W'(i));

    always_comb begin
      ctrl[i].tick      = advance && (in_op == rcnt_pkg::OP_TICK);
      ctrl[i].wr_count  = sel && (in_op == rcnt_pkg::OP_WR_COUNT);
      ctrl[i].wr_mode   = sel && (in_op == rcnt_pkg::OP_WR_MODE);
      ctrl[i].wr_target = sel && (in_op == rcnt_pkg::OP_WR_TARGET);
      ctrl[i].cfg_wr    = cfg_wr_en;
      ctrl[i].value     = in_val;
      ctrl[i].cfg_rate  = cfg_rate;
      ctrl[i].div_line  = div_line;
      ctrl[i].div_pix   = div_pix;
    end

    rcnt_channel u_chan (
      .clk       (clk),
      .rst       (rst),
      .id        (rcnt_pkg::CH_W'(i)),
      .ctrl      (ctrl[i]),
      .count_val (count_val[i]),
      .fire      (fire[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rd  <= (in_op == rcnt_pkg::OP_RD_COUNT) ? count_val[in_ch] : '0;
      out_irq <= fire;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = rcnt_pkg::M_TDATA_W'({out_irq, out_rd});

endmodule

// ----- design/rcnt_port_checker.sv -----
// Port-level checker of the counter/timer unit and its bind to the top level.
`timescale 1ns / 1ps
`include "four_channel_root_counter_timer_unit_assert.svh"

module rcnt_port_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rcnt_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [rcnt_pkg::CNT_W-1:0]    rd_field;
  logic [rcnt_pkg::CHANNELS-1:0] irq_field;
  logic                          in_beat;
  logic                          out_stall;

  assign rd_field  = m_tdata[rcnt_pkg::CNT_W-1:0];
  assign irq_field = m_tdata[rcnt_pkg::IRQ_MSB:rcnt_pkg::IRQ_LSB];
  assign in_beat   = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;

  // A beat carries either a read value or interrupt bits, never both.
  `RCNT_ASSERT_IMP(a_rd_irq_excl, clk, rst, m_tvalid, (rd_field == '0) || (irq_field == '0))

  // The result valid rises only after its beat was accepted and passed the input register.
  `RCNT_ASSERT_IMP(a_result_latency, clk, rst, $rose(m_tvalid), $past(in_beat, 2))

  // Input back-pressure only comes from a stalled result.
  `RCNT_ASSERT_IMP(a_ready_stall, clk, rst, !s_tready, out_stall)

  // A stalled result beat holds.
  `RCNT_ASSERT_NXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(m_tdata))

endmodule

bind four_channel_root_counter_timer_unit rcnt_port_checker u_port_checker (.*);
